FILE: hdl/asrr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asrr_pkg
// shared widths, register codes, controller states and control structs of
// the audio silence run remover
// ----------------------------------------------------------------------------
package asrr_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int LEVEL_W         = 15;
    localparam int LIM_W           = 7;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 15;
    localparam int MAX_RUN_DEFAULT = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LEVEL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SILENCE_RUN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_HELD,
        ST_LOUD
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_held;
        logic load_loud;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_flush;
        logic has_loud;
        logic last_entry;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/asrr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asrr_ctrl
// sequencer: takes one item, then walks the held-sample flush and the loud
// sample out through the output register
// ----------------------------------------------------------------------------
module asrr_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire asrr_pkg::dp_status_t  status,
    output asrr_pkg::ctrl_cmd_t        cmd,
    output logic                       in_stall
);

    asrr_pkg::state_t state_reg;
    asrr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asrr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            asrr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = asrr_pkg::ST_CHECK;
                end
            end
            asrr_pkg::ST_CHECK:
            begin
                if (status.has_flush)
                begin
                    state_next = asrr_pkg::ST_READ;
                end
                else if (status.has_loud)
                begin
                    state_next = asrr_pkg::ST_LOUD;
                end
                else
                begin
                    state_next = asrr_pkg::ST_IDLE;
                end
            end
            asrr_pkg::ST_READ:
            begin
                state_next = asrr_pkg::ST_HELD;
            end
            asrr_pkg::ST_HELD:
            begin
                if (status.out_free)
                begin
                    if (!status.last_entry)
                    begin
                        state_next = asrr_pkg::ST_READ;
                    end
                    else if (status.has_loud)
                    begin
                        state_next = asrr_pkg::ST_LOUD;
                    end
                    else
                    begin
                        state_next = asrr_pkg::ST_IDLE;
                    end
                end
            end
            asrr_pkg::ST_LOUD:
            begin
                if (status.out_free)
                begin
                    state_next = asrr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asrr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            asrr_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            asrr_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            asrr_pkg::ST_HELD:
            begin
                cmd.load_held = status.out_free;
            end
            asrr_pkg::ST_LOUD:
            begin
                cmd.load_loud = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/asrr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asrr_datapath
// config registers, quiet test, run counter, held-sample memory and the
// output register
// ----------------------------------------------------------------------------
module asrr_datapath
#(
    parameter int MAX_RUN = asrr_pkg::MAX_RUN_DEFAULT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [asrr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [asrr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic signed [asrr_pkg::SAMPLE_W-1:0]  sample_in,
    input  wire logic                                  stream_end,
    input  wire asrr_pkg::ctrl_cmd_t                   cmd,
    input  wire logic                                  out_stall,
    output asrr_pkg::dp_status_t                       status,
    output logic                                       out_valid,
    output logic signed [asrr_pkg::SAMPLE_W-1:0]       sample_out,
    output logic                                       burst_last
);

    localparam int SAMPLE_W = asrr_pkg::SAMPLE_W;
    localparam int LEVEL_W  = asrr_pkg::LEVEL_W;
    localparam int LIM_W    = asrr_pkg::LIM_W;
    localparam int ADDR_W   = $clog2(MAX_RUN);
    localparam int CNT_W    = $clog2(MAX_RUN + 1);
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_RUN);

    logic [LEVEL_W-1:0]         quiet_level_reg;
    logic [LIM_W-1:0]           min_run_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       dropping_reg;
    logic                       dropping_next;
    logic [CNT_W-1:0]           flush_len_reg;
    logic [CNT_W-1:0]           flush_len_next;
    logic                       loud_reg;
    logic                       loud_next;
    logic [CNT_W-1:0]           rd_idx_reg;
    logic [CNT_W-1:0]           rd_idx_next;
    logic [SAMPLE_W-1:0]        loud_sample_reg;
    logic [SAMPLE_W-1:0]        rd_data_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [SAMPLE_W-1:0]        sample_out_reg;
    logic                       burst_last_reg;
    logic [SAMPLE_W-1:0]        held_mem [MAX_RUN];

    logic signed [SAMPLE_W:0]   s_ext;
    logic signed [SAMPLE_W:0]   lvl_ext;
    logic                       quiet;
    logic [LIM_W-1:0]           lim;
    logic [LIM_W-1:0]           count_inc;
    logic                       hit;
    logic                       wr_en;
    logic                       last_entry;
    logic                       out_free;

    // quiet when -level <= sample <= level
    assign s_ext   = {sample_in[SAMPLE_W-1], sample_in};
    assign lvl_ext = $signed({2'b00, quiet_level_reg});
    assign quiet   = (s_ext >= -lvl_ext) && (s_ext <= lvl_ext);

    // run limit clamped to 1..MAX_RUN
    always_comb
    begin
        if (min_run_reg == '0)
        begin
            lim = LIM_W'(1);
        end
        else if (min_run_reg > MAX_LIM)
        begin
            lim = MAX_LIM;
        end
        else
        begin
            lim = min_run_reg;
        end
    end

    assign count_inc = LIM_W'(count_reg) + LIM_W'(1);
    assign hit       = count_inc >= lim;
    assign wr_en     = cmd.accept && quiet && !dropping_reg;

    assign last_entry = (rd_idx_reg + CNT_W'(1)) == flush_len_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        count_next     = count_reg;
        dropping_next  = dropping_reg;
        flush_len_next = flush_len_reg;
        loud_next      = loud_reg;
        rd_idx_next    = rd_idx_reg;
        if (cmd.accept)
        begin
            flush_len_next = '0;
            loud_next      = 1'b0;
            rd_idx_next    = '0;
            if (!quiet)
            begin
                flush_len_next = count_reg;
                loud_next      = 1'b1;
                dropping_next  = 1'b0;
                count_next     = '0;
            end
            else if (!dropping_reg)
            begin
                if (hit)
                begin
                    dropping_next = 1'b1;
                    count_next    = '0;
                end
                else if (stream_end)
                begin
                    flush_len_next = CNT_W'(count_inc);
                    count_next     = '0;
                end
                else
                begin
                    count_next = CNT_W'(count_inc);
                end
            end
            if (stream_end)
            begin
                count_next    = '0;
                dropping_next = 1'b0;
            end
        end
        if (cmd.load_held)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
            if (last_entry)
            begin
                flush_len_next = '0;
            end
        end
        if (cmd.load_loud)
        begin
            loud_next = 1'b0;
        end
    end

    assign out_valid_next = cmd.load_held || cmd.load_loud || (out_valid_reg && out_stall);

    // config registers and run control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_level_reg <= '0;
            min_run_reg     <= LIM_W'(1);
            count_reg       <= '0;
            dropping_reg    <= 1'b0;
            flush_len_reg   <= '0;
            loud_reg        <= 1'b0;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    asrr_pkg::CFG_QUIET_LEVEL:
                    begin
                        quiet_level_reg <= cfg_data[LEVEL_W-1:0];
                    end
                    asrr_pkg::CFG_MIN_SILENCE_RUN:
                    begin
                        min_run_reg <= cfg_data[LIM_W-1:0];
                    end
                    default:
                    begin
                        quiet_level_reg <= quiet_level_reg;
                    end
                endcase
            end
            count_reg     <= count_next;
            dropping_reg  <= dropping_next;
            flush_len_reg <= flush_len_next;
            loud_reg      <= loud_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            loud_sample_reg <= sample_in;
        end
        if (cmd.load_held)
        begin
            sample_out_reg <= rd_data_reg;
            burst_last_reg <= last_entry && !loud_reg;
        end
        else if (cmd.load_loud)
        begin
            sample_out_reg <= loud_sample_reg;
            burst_last_reg <= 1'b1;
        end
    end

    // held quiet samples
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            held_mem[count_reg[ADDR_W-1:0]] <= sample_in;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= held_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    assign status.has_flush  = flush_len_reg != '0;
    assign status.has_loud   = loud_reg;
    assign status.last_entry = last_entry;
    assign status.out_free   = out_free;

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign burst_last = burst_last_reg;

    // held count never reaches the buffer depth between items
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(MAX_RUN))
        else $error("held count out of range");

    // a dropped run holds nothing
    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> count_reg == '0)
        else $error("samples held while dropping");

    // a new item only starts once the previous burst is fully out
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (flush_len_reg == '0) && !loud_reg)
        else $error("item accepted during a burst");

    // flush reads stay inside the held run
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_issue || cmd.load_held) |-> rd_idx_reg < flush_len_reg)
        else $error("flush read beyond held run");

endmodule
`default_nettype wire

FILE: hdl/audio_silence_run_remover.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_silence_run_remover
// drops every maximal run of quiet samples at least min_silence_run long and
// passes all other samples through in order
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ----------------------------
//   in       sink       in_valid / in_stall       sample_in, stream_end
//   out      source     out_valid / out_stall     sample_out, burst_last
//   cfg      sink       cfg_write (no wait)       cfg_index, cfg_data
//
// one item at a time: accept, decide, then for each flushed held sample a
// registered memory read followed by an output load, and last an output
// load for a loud sample; held samples are read out one by one through
// the single read port of the held-sample memory.
// out_stall only stretches the output loads; in_stall is low in idle only
// reset clears control state; the held-sample memory needs no clearing pass
//
module audio_silence_run_remover
#(
    parameter int MAX_RUN = asrr_pkg::MAX_RUN_DEFAULT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration writes
    input  wire logic                                  cfg_write,
    input  wire logic [asrr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [asrr_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sample input beat
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [asrr_pkg::SAMPLE_W-1:0]  sample_in,
    input  wire logic                                  stream_end,
    // kept sample output beat
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [asrr_pkg::SAMPLE_W-1:0]       sample_out,
    output logic                                       burst_last
);

    // command and status between sequencer and datapath
    asrr_pkg::ctrl_cmd_t  cmd;
    asrr_pkg::dp_status_t status;

    // sequencer: idle, decide, then read/load held samples, then loud sample
    asrr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // datapath: quiet test, run count, held memory, output register
    asrr_datapath
    #(
        .MAX_RUN (MAX_RUN)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .stream_end (stream_end),
        .cmd        (cmd),
        .out_stall  (out_stall),
        .status     (status),
        .out_valid  (out_valid),
        .sample_out (sample_out),
        .burst_last (burst_last)
    );

endmodule
`default_nettype wire
